>>> hdl/mbed_pkg.sv
package mbed_pkg;

    localparam int NUM_BUTTONS = 4;
    localparam int BTN_W       = 2;
    localparam int TICK_W      = 16;
    localparam int CLICK_W     = 8;
    localparam int EVENT_W     = 4;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int S_DATA_W    = 8;
    localparam int M_DATA_W    = 16;

    localparam logic [BTN_W-1:0] LAST_BTN = BTN_W'(NUM_BUTTONS - 1);

    localparam logic [CFG_ADDR_W-1:0] REG_SHORT_PRESS = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LONG_PRESS  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LONG_HOLD   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_CLICK_GAP   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_CLICK_LIMIT = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_LEVEL_MASK  = 3'd5;

    localparam logic [EVENT_W-1:0] EV_NONE     = 4'd0;
    localparam logic [EVENT_W-1:0] EV_DOWN     = 4'd1;
    localparam logic [EVENT_W-1:0] EV_SHORT    = 4'd2;
    localparam logic [EVENT_W-1:0] EV_LONG     = 4'd3;
    localparam logic [EVENT_W-1:0] EV_HOLD     = 4'd4;
    localparam logic [EVENT_W-1:0] EV_SHORT_UP = 4'd5;
    localparam logic [EVENT_W-1:0] EV_LONG_UP  = 4'd6;
    localparam logic [EVENT_W-1:0] EV_HOLD_UP  = 4'd7;
    localparam logic [EVENT_W-1:0] EV_CLICKS   = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_DOWN  = 3'b010,
        ST_MULTI = 3'b100
    } t_stage;

    typedef struct packed {
        logic [TICK_W-1:0]  short_press;
        logic [TICK_W-1:0]  long_press;
        logic [TICK_W-1:0]  long_hold;
        logic [TICK_W-1:0]  click_gap;
        logic [CLICK_W-1:0] click_limit;
    } t_cfg;

    typedef struct packed {
        logic [EVENT_W-1:0] event_code;
        logic [CLICK_W-1:0] click_count;
    } t_lane_out;

endpackage

>>> hdl/mbed_lane.sv
module mbed_lane
    import mbed_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_pressed,
    input  t_cfg      i_cfg,
    output t_lane_out o_result
);

    t_stage             r_stage, n_stage;
    logic [TICK_W-1:0]  r_hold, n_hold;
    logic [CLICK_W-1:0] r_clicks, n_clicks;
    logic [EVENT_W-1:0] r_event, n_event;
    logic [CLICK_W-1:0] r_rep, n_rep;

    logic [TICK_W:0]    inc_ticks;
    logic [TICK_W-1:0]  cur_ticks;
    logic [CLICK_W-1:0] clipped;

    always_comb begin
        n_stage   = r_stage;
        n_clicks  = r_clicks;
        n_event   = r_event;
        n_rep     = r_rep;
        inc_ticks = {1'b0, r_hold} + {{TICK_W{1'b0}}, 1'b1};
        cur_ticks = r_hold;
        if (r_stage == ST_DOWN || r_stage == ST_MULTI) begin
            cur_ticks = (inc_ticks >= {1'b0, i_cfg.long_hold}) ? i_cfg.long_hold
                                                                : inc_ticks[TICK_W-1:0];
        end
        n_hold  = cur_ticks;
        clipped = (r_clicks < i_cfg.click_limit) ? r_clicks : i_cfg.click_limit;

        unique case (r_stage)
            ST_DOWN: begin
                if (i_pressed) begin
                    if (r_clicks != '0) begin
                        if (cur_ticks > i_cfg.click_gap) begin
                            n_event  = EV_CLICKS;
                            n_rep    = clipped;
                            n_hold   = '0;
                            n_clicks = '0;
                        end
                    end else if (cur_ticks >= i_cfg.long_hold) begin
                        n_event = EV_HOLD;
                    end else if (cur_ticks >= i_cfg.long_press) begin
                        n_event = EV_LONG;
                    end else if (cur_ticks >= i_cfg.short_press) begin
                        n_event = EV_SHORT;
                    end
                end else begin
                    if (cur_ticks >= i_cfg.long_hold) begin
                        n_event = EV_HOLD_UP;
                        n_stage = ST_IDLE;
                    end else if (cur_ticks >= i_cfg.long_press) begin
                        n_event = EV_LONG_UP;
                        n_stage = ST_IDLE;
                    end else if (cur_ticks >= i_cfg.short_press) begin
                        n_event = EV_SHORT_UP;
                        n_stage = ST_IDLE;
                    end else begin
                        n_stage = ST_MULTI;
                        if (r_clicks != {CLICK_W{1'b1}}) begin
                            n_clicks = r_clicks + CLICK_W'(1);
                        end
                    end
                end
            end
            ST_MULTI: begin
                if (i_pressed) begin
                    n_stage = ST_DOWN;
                    n_hold  = '0;
                end else if (cur_ticks > i_cfg.click_gap) begin
                    n_event = EV_CLICKS;
                    n_rep   = clipped;
                    n_stage = ST_IDLE;
                end
            end
            default: begin
                n_event = EV_NONE;
                n_stage = ST_IDLE;
                if (i_pressed) begin
                    n_event  = EV_DOWN;
                    n_stage  = ST_DOWN;
                    n_hold   = '0;
                    n_clicks = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage  <= ST_IDLE;
            r_hold   <= '0;
            r_clicks <= '0;
            r_event  <= EV_NONE;
            r_rep    <= '0;
        end else if (i_en) begin
            r_stage  <= n_stage;
            r_hold   <= n_hold;
            r_clicks <= n_clicks;
            r_event  <= n_event;
            r_rep    <= n_rep;
        end
    end

    assign o_result.event_code  = r_event;
    assign o_result.click_count = (r_event == EV_CLICKS) ? r_rep : '0;

endmodule

>>> hdl/mbed_merge.sv
module mbed_merge
    import mbed_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  t_lane_out           i_lanes [NUM_BUTTONS],
    input  logic                i_m_tready,
    output logic                o_busy_next,
    output logic                o_m_tvalid,
    output logic [M_DATA_W-1:0] o_m_tdata,
    output logic                o_m_tlast
);

    logic             r_valid;
    logic [BTN_W-1:0] r_idx;
    logic             last_taken;
    t_lane_out        sel;

    assign last_taken  = r_valid && i_m_tready && (r_idx == LAST_BTN);
    assign o_busy_next = r_valid && !last_taken;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_start) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (r_valid && i_m_tready) begin
            if (r_idx == LAST_BTN) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + BTN_W'(1);
            end
        end
    end

    assign sel        = i_lanes[r_idx];
    assign o_m_tvalid = r_valid;
    assign o_m_tlast  = (r_idx == LAST_BTN);
    assign o_m_tdata  = {2'b00, sel.click_count, sel.event_code, r_idx};

endmodule

>>> hdl/multi_button_event_detector_unit.sv
// Multi-button event detector.
// The slave channel takes one request per scan tick; tdata[3:0] holds the raw
// pin level of every button. Each button has its own lane that updates its
// press state in the cycle the request is accepted.
// The master channel then returns one request per button, button 0 first,
// with tlast on the highest-numbered button. Each carries the button index,
// the button's current event code and the clipped click count.
// The first result is valid in the cycle after the tick is accepted. The next
// tick is taken in the same cycle the last result of the previous tick is
// taken, so no new tick is accepted while results of the previous one remain;
// the single output port serializes the four lane results.
// When the receiver stalls, the current result holds and no new tick is
// accepted until the last result leaves.
// Reset clears all button state to idle with no event and restores the
// default thresholds. Configuration writes take effect at once. The user must
// do them while no tick is in flight; the block itself does not enforce this.
module multi_button_event_detector_unit
    import mbed_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // Fields from bit 0: pin_levels[3:0], zero fill.
    input  logic [S_DATA_W-1:0]   i_s_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // Fields from bit 0: button_index[1:0], event_code[5:2], click_count[13:6], zero fill.
    output logic [M_DATA_W-1:0]   o_m_tdata,
    output logic                  o_m_tlast
);

    t_cfg                   r_cfg;
    logic [NUM_BUTTONS-1:0] r_mask;
    logic [NUM_BUTTONS-1:0] pressed;
    logic                   accept;
    logic                   busy_next;
    t_lane_out              lanes [NUM_BUTTONS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_press <= TICK_W'(3);
            r_cfg.long_press  <= TICK_W'(50);
            r_cfg.long_hold   <= TICK_W'(100);
            r_cfg.click_gap   <= TICK_W'(15);
            r_cfg.click_limit <= CLICK_W'(3);
            r_mask            <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_SHORT_PRESS: r_cfg.short_press <= i_cfg_wdata;
                REG_LONG_PRESS:  r_cfg.long_press  <= i_cfg_wdata;
                REG_LONG_HOLD:   r_cfg.long_hold   <= i_cfg_wdata;
                REG_CLICK_GAP:   r_cfg.click_gap   <= i_cfg_wdata;
                REG_CLICK_LIMIT: r_cfg.click_limit <= i_cfg_wdata[CLICK_W-1:0];
                REG_LEVEL_MASK:  r_mask            <= i_cfg_wdata[NUM_BUTTONS-1:0];
                default: ;
            endcase
        end
    end

    assign o_s_tready = !busy_next;
    assign accept     = i_s_tvalid && o_s_tready;
    assign pressed    = ~(i_s_tdata[NUM_BUTTONS-1:0] ^ r_mask);

    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
        mbed_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (accept),
            .i_pressed (pressed[g]),
            .i_cfg     (r_cfg),
            .o_result  (lanes[g])
        );
    end

    mbed_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (accept),
        .i_lanes     (lanes),
        .i_m_tready  (i_m_tready),
        .o_busy_next (busy_next),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

`ifndef SYNTH
    a_accept_at_tick_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_s_tready && o_m_tvalid) |-> (o_m_tlast && i_m_tready))
        else $error("tick accepted while results of the previous tick remain");

    a_first_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (o_m_tvalid && o_m_tdata[1:0] == 2'd0))
        else $error("first result of a tick is not button zero");

    a_last_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tlast == (o_m_tdata[BTN_W-1:0] == LAST_BTN)))
        else $error("last marker does not match the button index");

    a_count_only_on_clicks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[13:6] != 8'd0) |-> (o_m_tdata[5:2] == EV_CLICKS))
        else $error("click count reported with a non-click event");
`endif

endmodule
